// ----- hdl/swr_pkg.sv -----
`timescale 1ns / 1ps

package swr_pkg;

    localparam int NUM_CH = 12;

    localparam int CMD_W   = 8;
    localparam int ADDR_W  = 8;
    localparam int DATA_W  = 8;
    localparam int CH_W    = 4;
    localparam int BOARD_W = 4;
    localparam int VOICE_W = 3;

    localparam int MUTE_W  = NUM_CH;
    localparam int BMAP_W  = NUM_CH * BOARD_W;
    localparam int VMAP_W  = NUM_CH * VOICE_W;
    localparam int CFG_W   = BMAP_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MUTE_MASK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODATA_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_MAP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOICE_MAP   = 2'd3;

    localparam logic [VMAP_W-1:0] VOICE_MAP_RESET = 36'd2283156544;

    localparam logic [3:0] UPPER_PLAIN = 4'h0;
    localparam logic [3:0] UPPER_ALT   = 4'h5;
    localparam logic [2:0] TYPE_PSG    = 3'd0;
    localparam logic [2:0] TYPE_FM     = 3'd1;

    localparam logic [ADDR_W-1:0] ADDR_TIMER_LO  = 8'h24;
    localparam logic [ADDR_W-1:0] ADDR_TIMER_HI  = 8'h27;
    localparam logic [ADDR_W-1:0] ADDR_KEY_ON    = 8'h28;
    localparam logic [ADDR_W-1:0] ADDR_DAC_DATA  = 8'h2A;
    localparam logic [ADDR_W-1:0] ADDR_DAC_EN    = 8'h2B;
    localparam logic [ADDR_W-1:0] ADDR_GLOBAL_HI = 8'h2F;
    localparam logic [ADDR_W-1:0] ADDR_CH3_LO    = 8'hA8;
    localparam logic [ADDR_W-1:0] ADDR_CH3_HI    = 8'hAE;
    localparam logic [ADDR_W-1:0] ADDR_GLOBAL_LO = 8'hB8;

    localparam logic [DATA_W-1:0] MASK_LATCH_KEEP = 8'h9F;
    localparam logic [DATA_W-1:0] MASK_KEY_KEEP   = 8'hF8;
    localparam logic [ADDR_W-1:0] MASK_ADDR_KEEP  = 8'hFC;
    localparam logic [CMD_W-1:0]  CMD_DROPPED     = 8'hFF;

    localparam logic [CH_W-1:0] CH_FM_GLOBAL = 4'd0;
    localparam logic [CH_W-1:0] CH_FM_VOICE1 = 4'd1;
    localparam logic [CH_W-1:0] CH_FM_VOICE3 = 4'd3;
    localparam logic [CH_W-1:0] CH_FM_VOICE4 = 4'd4;
    localparam logic [CH_W-1:0] CH_DAC       = 4'd7;
    localparam logic [CH_W-1:0] CH_PSG_BASE  = 4'd8;
    localparam logic [CH_W-1:0] CH_NOISE     = 4'd11;

    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_PSG_LATCH,
        KIND_KEY_ON,
        KIND_VOICE_REG
    } swr_kind_t;

    typedef struct packed {
        logic [CH_W-1:0]   chan;
        swr_kind_t         kind;
        logic              force_drop;
        logic              mute_chk;
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } swr_entry_t;

endpackage

// ----- hdl/swr_front.sv -----
`timescale 1ns / 1ps

module swr_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  logic [swr_pkg::CMD_W-1:0]  in_cmd,
    input  logic [swr_pkg::ADDR_W-1:0] in_addr,
    input  logic [swr_pkg::DATA_W-1:0] in_data,
    input  logic                     q_ready,
    output logic                     q_valid,
    output swr_pkg::swr_entry_t      q_entry
);
    import swr_pkg::*;

    logic [1:0]      latch_reg;
    logic [1:0]      latch_next;
    logic            cmd_ok;
    logic            is_psg;
    logic [2:0]      key_ch;
    logic [CH_W-1:0] voice_ch;

    assign cmd_ok = ((in_cmd[7:4] == UPPER_PLAIN) || (in_cmd[7:4] == UPPER_ALT)) &&
                    ((in_cmd[3:1] == TYPE_PSG) || (in_cmd[3:1] == TYPE_FM));
    assign is_psg = (in_cmd[3:1] == TYPE_PSG);
    assign key_ch = in_data[2:0];
    assign voice_ch = {2'b00, in_addr[1:0]} + (in_cmd[0] ? CH_FM_VOICE4 : CH_FM_VOICE1);

    always_comb begin
        latch_next = latch_reg;
        q_entry.chan       = CH_FM_GLOBAL;
        q_entry.kind       = KIND_PLAIN;
        q_entry.force_drop = 1'b0;
        q_entry.mute_chk   = 1'b0;
        q_entry.cmd        = in_cmd;
        q_entry.addr       = in_addr;
        q_entry.data       = in_data;
        if (!cmd_ok) begin
            q_entry.force_drop = 1'b1;
        end else if (is_psg) begin
            if (in_data[7]) begin
                latch_next = in_data[6:5];
                q_entry.chan     = CH_PSG_BASE + {2'b00, in_data[6:5]};
                q_entry.kind     = KIND_PSG_LATCH;
                q_entry.mute_chk = in_data[4];
            end else begin
                q_entry.chan = CH_PSG_BASE + {2'b00, latch_reg};
            end
        end else if (in_addr == ADDR_KEY_ON) begin
            q_entry.kind       = KIND_KEY_ON;
            q_entry.mute_chk   = 1'b1;
            q_entry.force_drop = (key_ch[1:0] == 2'd3);
            q_entry.chan       = (key_ch < 3'd3) ? {1'b0, key_ch} + 4'd1 : {1'b0, key_ch};
        end else if ((in_addr == ADDR_DAC_DATA) || (in_addr == ADDR_DAC_EN)) begin
            q_entry.chan     = CH_DAC;
            q_entry.mute_chk = (in_addr == ADDR_DAC_DATA);
        end else if (((in_addr >= ADDR_CH3_LO) && (in_addr <= ADDR_CH3_HI)) ||
                     ((in_addr >= ADDR_TIMER_LO) && (in_addr <= ADDR_TIMER_HI))) begin
            q_entry.chan = CH_FM_VOICE3;
        end else if ((in_addr <= ADDR_GLOBAL_HI) || (in_addr >= ADDR_GLOBAL_LO)) begin
            q_entry.chan = CH_FM_GLOBAL;
        end else begin
            q_entry.kind       = KIND_VOICE_REG;
            q_entry.force_drop = (in_addr[1:0] == 2'd3);
            q_entry.chan       = voice_ch;
        end
    end

    assign q_valid = in_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg <= 2'd0;
        end else if (in_valid && q_ready) begin
            latch_reg <= latch_next;
        end
    end

endmodule

// ----- hdl/swr_fifo.sv -----
`timescale 1ns / 1ps

module swr_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  swr_pkg::swr_entry_t wr_entry,
    output logic                rd_valid,
    input  logic                rd_ready,
    output swr_pkg::swr_entry_t rd_entry
);
    import swr_pkg::*;

    swr_entry_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_entry = mem[rd_ptr_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

// ----- hdl/swr_back.sv -----
`timescale 1ns / 1ps

module swr_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  swr_pkg::swr_entry_t        q_entry,
    input  logic [swr_pkg::MUTE_W-1:0] mute_mask,
    input  logic [swr_pkg::MUTE_W-1:0] nodata_mask,
    input  logic [swr_pkg::BMAP_W-1:0] board_map,
    input  logic [swr_pkg::VMAP_W-1:0] voice_map,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_dropped,
    output logic [swr_pkg::CMD_W-1:0]  out_cmd,
    output logic [swr_pkg::ADDR_W-1:0] out_addr,
    output logic [swr_pkg::DATA_W-1:0] out_data
);
    import swr_pkg::*;

    logic                 valid_reg;
    logic                 dropped_reg;
    logic [CMD_W-1:0]     cmd_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [DATA_W-1:0]    data_reg;
    logic                 dropped_next;
    logic [CMD_W-1:0]     cmd_next;
    logic [ADDR_W-1:0]    addr_next;
    logic [DATA_W-1:0]    data_next;
    logic [5:0]           board_pos;
    logic [5:0]           voice_pos;
    logic [BOARD_W-1:0]   board;
    logic [VOICE_W-1:0]   voice;
    logic [3:0]           voice_adj;
    logic                 port;

    assign board_pos = {q_entry.chan, 2'b00};
    assign voice_pos = {2'b00, q_entry.chan} + {1'b0, q_entry.chan, 1'b0};
    assign board = board_map[board_pos +: BOARD_W];
    assign voice = voice_map[voice_pos +: VOICE_W];
    assign voice_adj = (voice >= 3'd3) ? {1'b0, voice} + 4'd1 : {1'b0, voice};

    always_comb begin
        dropped_next = q_entry.force_drop || nodata_mask[q_entry.chan] ||
                       (q_entry.mute_chk && mute_mask[q_entry.chan]);
        port      = q_entry.cmd[0];
        addr_next = q_entry.addr;
        data_next = q_entry.data;
        unique case (q_entry.kind)
            KIND_PSG_LATCH: begin
                if (q_entry.chan != CH_NOISE) begin
                    data_next = (q_entry.data & MASK_LATCH_KEEP) | {voice, 5'b00000};
                end
            end
            KIND_KEY_ON: begin
                data_next = (q_entry.data & MASK_KEY_KEEP) | {4'b0000, voice_adj};
            end
            KIND_VOICE_REG: begin
                port      = voice_adj[2];
                addr_next = (q_entry.addr & MASK_ADDR_KEEP) | {6'b000000, voice_adj[1:0]};
            end
            default: begin
            end
        endcase
        cmd_next = {board, q_entry.cmd[3:1], port};
        if (dropped_next) begin
            cmd_next  = CMD_DROPPED;
            addr_next = q_entry.addr;
            data_next = q_entry.data;
        end
    end

    assign q_ready     = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign out_dropped = dropped_reg;
    assign out_cmd     = cmd_reg;
    assign out_addr    = addr_reg;
    assign out_data    = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_ready) begin
            valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_ready && q_valid) begin
            dropped_reg <= dropped_next;
            cmd_reg     <= cmd_next;
            addr_reg    <= addr_next;
            data_reg    <= data_next;
        end
    end

endmodule

// ----- hdl/sound_chip_write_router.sv -----
`timescale 1ns / 1ps

// Routes one sound-chip write per transfer to a target board and voice. The front end
// decodes the command and address into one of twelve logical channels and tracks the
// last PSG latch channel; a two-entry queue then feeds the back end, which applies the
// channel's mute, no-data, board and voice settings and holds the result in an output
// register. One write is taken every clock cycle while the queue has room, and each result
// passes through the queue and then the output register before it is presented. Dropped
// writes carry m_tuser high and a command byte of all ones. Configuration must be written
// only while idle; the block itself does not enforce this.
module sound_chip_write_router (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [swr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swr_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,  // in_cmd, in_addr, in_data
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,  // out_cmd, out_addr, out_data
    output logic                          m_tuser   // dropped
);
    import swr_pkg::*;

    logic [MUTE_W-1:0] mute_mask_reg;
    logic [MUTE_W-1:0] nodata_mask_reg;
    logic [BMAP_W-1:0] board_map_reg;
    logic [VMAP_W-1:0] voice_map_reg;

    logic       f_valid;
    logic       f_ready;
    swr_entry_t f_entry;
    logic       b_valid;
    logic       b_ready;
    swr_entry_t b_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mute_mask_reg   <= '0;
            nodata_mask_reg <= '0;
            board_map_reg   <= '0;
            voice_map_reg   <= VOICE_MAP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MUTE_MASK:   mute_mask_reg   <= cfg_wdata[MUTE_W-1:0];
                REG_NODATA_MASK: nodata_mask_reg <= cfg_wdata[MUTE_W-1:0];
                REG_BOARD_MAP:   board_map_reg   <= cfg_wdata[BMAP_W-1:0];
                REG_VOICE_MAP:   voice_map_reg   <= cfg_wdata[VMAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    swr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_cmd   (s_tdata[7:0]),
        .in_addr  (s_tdata[15:8]),
        .in_data  (s_tdata[23:16]),
        .q_ready  (f_ready),
        .q_valid  (f_valid),
        .q_entry  (f_entry)
    );

    assign s_tready = f_ready;

    swr_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_entry (f_entry),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_entry (b_entry)
    );

    swr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (b_valid),
        .q_ready     (b_ready),
        .q_entry     (b_entry),
        .mute_mask   (mute_mask_reg),
        .nodata_mask (nodata_mask_reg),
        .board_map   (board_map_reg),
        .voice_map   (voice_map_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_dropped (m_tuser),
        .out_cmd     (m_tdata[7:0]),
        .out_addr    (m_tdata[15:8]),
        .out_data    (m_tdata[23:16])
    );

endmodule

// ----- verif/sound_chip_write_router_test.sv -----
`timescale 1ns / 1ps

module sound_chip_write_router_test;

    import swr_pkg::*;

    typedef struct packed {
        logic              dropped;
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } route_t;

    class route_scoreboard;
        logic [MUTE_W-1:0] mute_bits;
        logic [MUTE_W-1:0] nodata_bits;
        logic [BMAP_W-1:0] board_bits;
        logic [VMAP_W-1:0] voice_bits;
        logic [1:0]        last_latch;
        route_t            pending[$];
        int                writes;
        int                dropped;
        int                errors;

        function new();
            mute_bits   = '0;
            nodata_bits = '0;
            board_bits  = '0;
            voice_bits  = VOICE_MAP_RESET;
            last_latch  = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_MUTE_MASK:   mute_bits   = value[MUTE_W-1:0];
                REG_NODATA_MASK: nodata_bits = value[MUTE_W-1:0];
                REG_BOARD_MAP:   board_bits  = value[BMAP_W-1:0];
                REG_VOICE_MAP:   voice_bits  = value[VMAP_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [BOARD_W-1:0] board_of(int c);
            return board_bits[BOARD_W*c +: BOARD_W];
        endfunction

        function logic [VOICE_W-1:0] voice_of(int c);
            return voice_bits[VOICE_W*c +: VOICE_W];
        endfunction

        // Routing of one write; the PSG latch channel is updated as a side effect.
        function route_t route(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] in_addr,
                               logic [DATA_W-1:0] in_data);
            logic [ADDR_W-1:0]  addr;
            logic [DATA_W-1:0]  data;
            logic [BOARD_W-1:0] board;
            logic [3:0]         v;
            logic               port;
            logic               drop;
            int                 ch;
            addr  = in_addr;
            data  = in_data;
            port  = cmd[0];
            board = '0;
            drop  = 1'b0;
            if ((cmd[7:4] != UPPER_PLAIN && cmd[7:4] != UPPER_ALT) ||
                (cmd[3:1] != TYPE_PSG && cmd[3:1] != TYPE_FM)) begin
                drop = 1'b1;
            end else if (cmd[3:1] == TYPE_PSG) begin
                if (data[7]) begin
                    last_latch = data[6:5];
                    ch = int'(CH_PSG_BASE) + int'(last_latch);
                    if (nodata_bits[ch] || (data[4] && mute_bits[ch])) begin
                        drop = 1'b1;
                    end else begin
                        board = board_of(ch);
                        if (ch != CH_NOISE)
                            data = (data & MASK_LATCH_KEEP) | {voice_of(ch), 5'b0};
                    end
                end else begin
                    ch = int'(CH_PSG_BASE) + int'(last_latch);
                    if (nodata_bits[ch]) drop = 1'b1;
                    else board = board_of(ch);
                end
            end else if (addr == ADDR_KEY_ON) begin
                ch = int'(data[2:0]);
                if (ch[1:0] == 2'b11) begin
                    drop = 1'b1;
                end else begin
                    if (ch < 3) ch = ch + 1;
                    if (nodata_bits[ch] || mute_bits[ch]) begin
                        drop = 1'b1;
                    end else begin
                        board = board_of(ch);
                        v = {1'b0, voice_of(ch)};
                        if (v >= 4'd3) v = v + 4'd1;
                        data = (data & MASK_KEY_KEEP) | {4'b0, v};
                    end
                end
            end else if (addr == ADDR_DAC_DATA || addr == ADDR_DAC_EN) begin
                if (nodata_bits[CH_DAC] || (addr == ADDR_DAC_DATA && mute_bits[CH_DAC]))
                    drop = 1'b1;
                else
                    board = board_of(CH_DAC);
            end else if ((addr >= ADDR_CH3_LO && addr <= ADDR_CH3_HI) ||
                         (addr >= ADDR_TIMER_LO && addr <= ADDR_TIMER_HI)) begin
                if (nodata_bits[CH_FM_VOICE3]) drop = 1'b1;
                else board = board_of(CH_FM_VOICE3);
            end else if (addr <= ADDR_GLOBAL_HI || addr >= ADDR_GLOBAL_LO) begin
                if (nodata_bits[CH_FM_GLOBAL]) drop = 1'b1;
                else board = board_of(CH_FM_GLOBAL);
            end else begin
                ch = int'(addr[1:0]);
                if (ch == 3) begin
                    drop = 1'b1;
                end else begin
                    ch = ch + 3 * int'(port) + int'(CH_FM_VOICE1);
                    if (nodata_bits[ch]) begin
                        drop = 1'b1;
                    end else begin
                        board = board_of(ch);
                        v = {1'b0, voice_of(ch)};
                        if (v >= 4'd3) v = v + 4'd1;
                        port = v[2];
                        addr = (addr & MASK_ADDR_KEEP) | {6'b0, v[1:0]};
                    end
                end
            end
            if (drop) return '{1'b1, CMD_DROPPED, in_addr, in_data};
            return '{1'b0, {board, cmd[3:1], port}, addr, data};
        endfunction

        function void note_write(logic [23:0] word);
            pending.push_back(route(word[7:0], word[15:8], word[23:16]));
            writes++;
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [23:0] word, logic drop_flag);
            route_t want;
            if (pending.size() == 0) begin
                $error("result 0x%06h arrived with no write outstanding", word);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want.dropped) dropped++;
            compare("dropped", 32'(want.dropped), 32'(drop_flag));
            compare("out_cmd", 32'(want.cmd), 32'(word[7:0]));
            compare("out_addr", 32'(want.addr), 32'(word[15:8]));
            compare("out_data", 32'(want.data), 32'(word[23:16]));
        endfunction
    endclass

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 140;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [23:0]       m_tdata;
    logic              m_tuser;

    route_scoreboard book = new();
    int  source_idle_pct = 0;
    int  sink_stall_pct  = 0;
    bit  hold_request    = 1'b0;
    int  hold_left       = 0;
    int  quiet_cycles    = 0;

    sound_chip_write_router dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) book.check_result(m_tdata, m_tuser);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sound_chip_write_router test failed");
            $finish;
        end
    end

    function automatic logic [23:0] pack_write(logic [7:0] cmd, logic [7:0] addr,
                                               logic [7:0] data);
        return {data, addr, cmd};
    endfunction

    function automatic logic [23:0] random_write();
        logic [7:0] cmd;
        logic [7:0] addr;
        logic [7:0] data;
        logic [3:0] upper;
        logic       port;
        int         pick;
        pick  = $urandom_range(99);
        upper = $urandom_range(1) ? UPPER_ALT : UPPER_PLAIN;
        port  = 1'($urandom_range(1));
        cmd   = {upper, TYPE_FM, port};
        addr  = 8'($urandom);
        data  = 8'($urandom);
        if (pick < 8) begin
            cmd = 8'($urandom);
        end else if (pick < 30) begin
            cmd = {upper, TYPE_PSG, port};
            data[7] = 1'b1;
        end else if (pick < 45) begin
            cmd = {upper, TYPE_PSG, port};
            data[7] = 1'b0;
        end else if (pick < 58) begin
            addr = ADDR_KEY_ON;
        end else if (pick < 64) begin
            addr = $urandom_range(1) ? ADDR_DAC_DATA : ADDR_DAC_EN;
        end else if (pick < 70) begin
            addr = 8'($urandom_range(1) ? $urandom_range(ADDR_TIMER_HI, ADDR_TIMER_LO)
                                        : $urandom_range(ADDR_CH3_HI, ADDR_CH3_LO));
        end else if (pick < 78) begin
            addr = 8'($urandom_range(1) ? $urandom_range(ADDR_GLOBAL_HI, 0)
                                        : $urandom_range(8'hFF, ADDR_GLOBAL_LO));
        end else begin
            addr = 8'($urandom_range(ADDR_GLOBAL_LO - 1, ADDR_GLOBAL_HI + 1));
        end
        return {data, addr, cmd};
    endfunction

    task automatic send_write(input logic [23:0] word);
        while ($urandom_range(99) < source_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        book.note_write(word);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (book.pending.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        book.set_reg(idx, value);
    endtask

    task automatic configure(input logic [MUTE_W-1:0] mute, input logic [MUTE_W-1:0] nodata,
                             input logic [BMAP_W-1:0] boards, input logic [VMAP_W-1:0] voices);
        write_reg(REG_MUTE_MASK, CFG_W'(mute));
        write_reg(REG_NODATA_MASK, CFG_W'(nodata));
        write_reg(REG_BOARD_MAP, boards);
        write_reg(REG_VOICE_MAP, CFG_W'(voices));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [23:0] directed[$];
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed = '{
            pack_write(8'hFF, 8'h00, 8'h00),
            pack_write(8'h06, 8'hFF, 8'hFF),
            pack_write(8'hA2, 8'h30, 8'h01),
            pack_write(8'h00, 8'h00, 8'hB5),
            pack_write(8'h51, 8'hFF, 8'h3F),
            pack_write(8'h00, 8'h00, 8'hE7),
            pack_write(8'h02, ADDR_KEY_ON, 8'hF0),
            pack_write(8'h52, ADDR_KEY_ON, 8'h05),
            pack_write(8'h03, ADDR_KEY_ON, 8'h03),
            pack_write(8'h02, ADDR_KEY_ON, 8'hFF),
            pack_write(8'h02, ADDR_DAC_DATA, 8'h80),
            pack_write(8'h53, ADDR_DAC_EN, 8'h80),
            pack_write(8'h02, ADDR_TIMER_HI, 8'h15),
            pack_write(8'h03, ADDR_CH3_HI, 8'h22),
            pack_write(8'h02, ADDR_GLOBAL_LO, 8'hFF),
            pack_write(8'h03, 8'hFF, 8'h7F),
            pack_write(8'h02, 8'h30, 8'h1F),
            pack_write(8'h53, 8'hB6, 8'hAA),
            pack_write(8'h02, 8'h33, 8'h44)
        };
        foreach (directed[i]) send_write(directed[i]);
        drain();

        // Muted and no-data channels, with every voice at seven.
        configure(12'h2A2, 12'h410, 48'hFEDCBA987654, {VMAP_W{1'b1}});
        directed = '{
            pack_write(8'h00, 8'h00, 8'hC0),
            pack_write(8'h50, 8'h00, 8'h12),
            pack_write(8'h00, 8'h00, 8'hBF),
            pack_write(8'h01, 8'h00, 8'h0F),
            pack_write(8'h00, 8'h00, 8'hA5),
            pack_write(8'h00, 8'h00, 8'hF0),
            pack_write(8'h02, ADDR_DAC_DATA, 8'h7F),
            pack_write(8'h03, ADDR_DAC_EN, 8'h00),
            pack_write(8'h02, ADDR_KEY_ON, 8'h01),
            pack_write(8'h02, ADDR_KEY_ON, 8'hF0),
            pack_write(8'h02, 8'h41, 8'h00),
            pack_write(8'h03, 8'h50, 8'h00)
        };
        foreach (directed[i]) send_write(directed[i]);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: configure('0, '0, '0, VOICE_MAP_RESET);
                1: configure({MUTE_W{1'b1}}, '0, {BMAP_W{1'b1}}, {VMAP_W{1'b1}});
                2: configure('0, {MUTE_W{1'b1}}, '0, '0);
                default: configure(MUTE_W'($urandom), MUTE_W'($urandom & $urandom & $urandom),
                                   BMAP_W'({$urandom, $urandom}),
                                   VMAP_W'({$urandom, $urandom}));
            endcase
            case (p % 4)
                0: begin source_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin source_idle_pct = 71; sink_stall_pct = 0;  end
                2: begin source_idle_pct = 0;  sink_stall_pct = 71; end
                default: begin source_idle_pct = 16; sink_stall_pct = 16; end
            endcase
            // The output side holds off for a long stretch so that the input backs up.
            if (p == 0) hold_request = 1'b1;
            repeat (PHASE_ITEMS) send_write(random_write());
            drain();
        end

        $display("Routed %0d writes (%0d dropped) across %0d register settings,",
                 book.writes, book.dropped, PHASES + 2);
        $display("with idle source, stalled sink and a long output hold-off.");
        if (book.errors == 0) begin
            $display("sound_chip_write_router test passed");
        end else begin
            $display("sound_chip_write_router test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/swr_pkg.sv
hdl/swr_front.sv
hdl/swr_fifo.sv
hdl/swr_back.sv
hdl/sound_chip_write_router.sv
verif/sound_chip_write_router_test.sv
